### design/usb_pkg.sv
// ----------------------------------------------------------------------------
// usb_pkg
// Shared types and constants for the unsorted subarray bounds block.
// ----------------------------------------------------------------------------
`default_nettype none

package usb_pkg;

	localparam int MAX_LEN    = 1024;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(MAX_LEN);
	localparam int CNT_W      = IDX_W + 1;
	localparam int OUT_IDX_W  = 10;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic                         last;
	} in_word_t;

	typedef struct packed {
		logic                 unsorted;
		logic [OUT_IDX_W-1:0] left_index;
		logic [OUT_IDX_W-1:0] right_index;
		logic                 overflow;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_SCAN,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

### design/unsorted_subarray_bounds.sv
// ----------------------------------------------------------------------------
// unsorted_subarray_bounds
// Finds the first and last index where a stored sequence differs from its
// sorted copy.
// ----------------------------------------------------------------------------
// Words are loaded one per cycle while busy is low; the prefix maximum and
// the right bound are tracked as words arrive. The word with last set starts
// a backward pass over the element memory, one read per cycle, that tracks
// the suffix minimum for the left bound. Both passes share one signed
// comparator. After the last word of an n-element sequence (n capped at
// 1024) busy stays high until the result is shown with done for one cycle;
// the receiver cannot stall it. Words past 1024 are dropped and reported
// through the overflow flag.
`default_nettype none

module unsorted_subarray_bounds (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire usb_pkg::in_word_t  req,
	output logic                    done,
	output usb_pkg::out_word_t      rsp
);
	import usb_pkg::*;

	logic signed [VALUE_BITS-1:0] mem [MAX_LEN];

	state_t state_q, state_d;

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             found_q;
	logic [IDX_W-1:0] left_q;
	logic [IDX_W-1:0] right_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] pos_q;
	logic             issue_q;
	logic             rvalid_q;

	logic signed [VALUE_BITS-1:0] hi_q;
	logic signed [VALUE_BITS-1:0] lo_q;
	logic signed [VALUE_BITS-1:0] rdata_q;

	logic signed [VALUE_BITS-1:0] cmp_a;
	logic signed [VALUE_BITS-1:0] cmp_b;
	logic                         cmp_lt;

	logic accept;
	logic has_room;
	logic scan_end;

	assign accept   = start && !busy;
	assign has_room = count_q < CNT_W'(MAX_LEN);
	assign scan_end = rvalid_q && (pos_q == '0);

	// shared comparator
	always_comb begin
		if (state_q == ST_FILL) begin
			cmp_a = req.value;
			cmp_b = hi_q;
		end else begin
			cmp_a = lo_q;
			cmp_b = rdata_q;
		end
		cmp_lt = cmp_a < cmp_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			ST_FILL: begin
				busy = 1'b0;
				if (accept && req.last) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				done    = 1'b1;
				state_d = ST_FILL;
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && has_room) begin
			mem[count_q[IDX_W-1:0]] <= req.value;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			found_q  <= 1'b0;
			issue_q  <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_FILL: begin
					if (accept) begin
						if (has_room) begin
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (req.last) begin
							found_q  <= 1'b0;
							issue_q  <= 1'b1;
							rvalid_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					rvalid_q <= issue_q;
					if (issue_q && idx_q == '0) begin
						issue_q <= 1'b0;
					end
					if (rvalid_q && cmp_lt) begin
						found_q <= 1'b1;
					end
				end
				ST_OUT: begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
				default: begin
					count_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_FILL: begin
				if (accept && has_room) begin
					if (count_q == '0) begin
						hi_q    <= req.value;
						right_q <= '0;
					end else if (cmp_lt) begin
						right_q <= count_q[IDX_W-1:0];
					end else begin
						hi_q <= req.value;
					end
				end
				if (accept && req.last) begin
					idx_q  <= has_room ? count_q[IDX_W-1:0] : IDX_W'(MAX_LEN - 1);
					left_q <= '0;
					lo_q   <= {1'b0, {(VALUE_BITS-1){1'b1}}};
				end
			end
			ST_SCAN: begin
				if (issue_q) begin
					pos_q <= idx_q;
					if (idx_q != '0) begin
						idx_q <= idx_q - 1'b1;
					end
				end
				// suffix minimum
				if (rvalid_q) begin
					if (cmp_lt) begin
						left_q <= pos_q;
					end else begin
						lo_q <= rdata_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rsp.unsorted    = found_q;
		rsp.left_index  = found_q ? OUT_IDX_W'(left_q) : '0;
		rsp.right_index = found_q ? OUT_IDX_W'(right_q) : '0;
		rsp.overflow    = ovf_q;
	end

`ifndef SYNTHESIS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result word shown while not busy");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block not free after result word");

	a_sorted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.unsorted) |-> (rsp.left_index == '0 && rsp.right_index == '0))
		else $error("sorted result carries bounds");

	a_bound_order: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.unsorted) |-> (rsp.left_index < rsp.right_index))
		else $error("left bound not below right bound");

	a_last_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.last) |=> (busy && !done))
		else $error("last word did not start the scan");
`endif

endmodule

`default_nettype wire
